[hdl/dtq_pkg.sv]
`default_nettype none

package dtq_pkg;

    // Sizing
    localparam int QUEUE_DEPTH   = 16;
    localparam int TIME_WIDTH    = 32;
    localparam int TASK_ID_WIDTH = 8;
    localparam int ORDER_WIDTH   = 16;
    localparam int RESULT_LIMIT  = 16;
    localparam int REL_LIMIT     = (QUEUE_DEPTH < RESULT_LIMIT) ? QUEUE_DEPTH : RESULT_LIMIT;
    localparam int IDX_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int REL_W         = $clog2(REL_LIMIT + 1);

    // Port field widths
    localparam int ID_PORT_W     = 8;
    localparam int DELAY_W       = 16;
    localparam int KIND_W        = 2;
    localparam int PEND_W        = 5;

    // Input modes
    localparam logic MODE_SCHED = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd2;

    // Record carried from cell to cell by a sweep
    typedef struct packed {
        logic                     act;
        logic                     sched;
        logic                     found;
        logic [TIME_WIDTH-1:0]    dl;
        logic [ORDER_WIDTH-1:0]   age;
        logic [IDX_W-1:0]         idx;
        logic [TASK_ID_WIDTH-1:0] tid;
    } carry_t;

    // New entry offered to the first free cell
    typedef struct packed {
        logic [TIME_WIDTH-1:0]    dl;
        logic [TASK_ID_WIDTH-1:0] tid;
        logic [ORDER_WIDTH-1:0]   ord;
    } wr_t;

    // Slot release strobe
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } clr_t;

    // a - b taken as a signed TIME_WIDTH value is negative
    function automatic logic time_before(input logic [TIME_WIDTH-1:0] a,
                                         input logic [TIME_WIDTH-1:0] b);
        logic [TIME_WIDTH-1:0] d;
        d = a - b;
        return d[TIME_WIDTH-1];
    endfunction

    // Pending count as seen on the port (low bits only)
    function automatic logic [PEND_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+PEND_W-1:0] t;
        t = (CNT_W + PEND_W)'(c);
        return t[PEND_W-1:0];
    endfunction

    // Stored task identifier as seen on the port
    function automatic logic [ID_PORT_W-1:0] id_out(input logic [TASK_ID_WIDTH-1:0] id);
        logic [TASK_ID_WIDTH+ID_PORT_W-1:0] t;
        t = (TASK_ID_WIDTH + ID_PORT_W)'(id);
        return t[ID_PORT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/deadline_timer_queue.sv]
// Earliest-deadline timer queue.
// Input channel (in_valid/in_ready): mode 0 schedules task_id due delay ticks
// from now; mode 1 advances time by one tick. Output channel (out_valid/
// out_ready): kind, released_id, last, pending_count.
// A schedule item gives one result (accepted or rejected when all slots are
// taken), with last set. A tick releases every due task, earliest deadline
// first, ties in arrival order, up to sixteen; the final one carries last. A
// tick with nothing due gives no result.
// Work is done by a sweep that walks the row of QUEUE_DEPTH cells, one cell
// per cycle. One item is in work at a time and in_ready is high only when
// the block is idle.
// A result sits in an output register; when the receiver stalls the block
// holds the next result and waits, with state unchanged.
// Reset clears time, the arrival counter and every slot; the block is ready
// in the first cycle after reset is released.
`default_nettype none

module deadline_timer_queue
    import dtq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 mode,
    input  wire logic [ID_PORT_W-1:0] task_id,
    input  wire logic [DELAY_W-1:0]   delay,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [KIND_W-1:0]         kind,
    output logic [ID_PORT_W-1:0]      released_id,
    output logic                      last,
    output logic [PEND_W-1:0]         pending_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        NX_IDLE,
        NX_LAUNCH,
        NX_FLUSH
    } after_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [TASK_ID_WIDTH-1:0] tid;
        logic                     last;
        logic [CNT_W-1:0]         cnt;
    } res_t;

    state_t                   state_reg;
    after_t                   nxt_reg;
    logic [TIME_WIDTH-1:0]    now_reg;
    logic [ORDER_WIDTH-1:0]   arr_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [REL_W-1:0]         rel_reg;
    wr_t                      wr_reg;
    res_t                     res_reg;
    res_t                     held_reg;
    logic                     held_vld_reg;
    carry_t                   launch_reg;
    logic                     out_valid_reg;
    res_t                     out_reg;

    carry_t                   chain [QUEUE_DEPTH+1];
    carry_t                   end_c;
    logic [QUEUE_DEPTH-1:0]   valid_vec;
    logic [QUEUE_DEPTH:0]     act_vec;
    clr_t                     clr;
    logic                     sweep_done;
    logic                     out_free;
    logic                     in_xfer;
    logic [REL_W-1:0]         rel_inc;
    logic                     limit_hit;
    res_t                     new_rel;

    // Row of cells
    assign chain[0] = launch_reg;
    assign act_vec[0] = launch_reg.act;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        dtq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_W'(i)),
            .now_time  (now_reg),
            .arrival   (arr_reg),
            .wr        (wr_reg),
            .clr       (clr),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1]),
            .valid     (valid_vec[i])
        );
        assign act_vec[i+1] = chain[i+1].act;
    end

    assign end_c = chain[QUEUE_DEPTH];

    // Sweep outcome and release strobe
    assign sweep_done = (state_reg == ST_SWEEP) && end_c.act;
    assign clr.en     = sweep_done && !end_c.sched && end_c.found;
    assign clr.idx    = end_c.idx;

    assign rel_inc   = rel_reg + REL_W'(1);
    assign limit_hit = (rel_inc == REL_W'(REL_LIMIT));

    always_comb
    begin
        new_rel.kind = KIND_RELEASED;
        new_rel.tid  = end_c.tid;
        new_rel.last = 1'b0;
        new_rel.cnt  = cnt_reg - CNT_W'(1);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Control sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nxt_reg       <= NX_IDLE;
            now_reg       <= '0;
            arr_reg       <= '0;
            cnt_reg       <= '0;
            rel_reg       <= '0;
            wr_reg        <= '0;
            res_reg       <= '0;
            held_reg      <= '0;
            held_vld_reg  <= 1'b0;
            launch_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            launch_reg.act <= 1'b0;

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        wr_reg.dl  <= now_reg + TIME_WIDTH'(delay);
                        wr_reg.tid <= task_id[TASK_ID_WIDTH-1:0];
                        wr_reg.ord <= arr_reg;
                        if (mode == MODE_TICK)
                            now_reg <= now_reg + TIME_WIDTH'(1);
                        rel_reg          <= '0;
                        held_vld_reg     <= 1'b0;
                        launch_reg       <= '0;
                        launch_reg.act   <= 1'b1;
                        launch_reg.sched <= (mode == MODE_SCHED);
                        state_reg        <= ST_SWEEP;
                    end
                end

                ST_SWEEP:
                begin
                    if (sweep_done)
                    begin
                        if (end_c.sched)
                        begin
                            res_reg.tid  <= wr_reg.tid;
                            res_reg.last <= 1'b1;
                            if (end_c.found)
                            begin
                                res_reg.kind <= KIND_ACCEPTED;
                                res_reg.cnt  <= cnt_reg + CNT_W'(1);
                                cnt_reg      <= cnt_reg + CNT_W'(1);
                                arr_reg      <= arr_reg + ORDER_WIDTH'(1);
                            end
                            else
                            begin
                                res_reg.kind <= KIND_REJECTED;
                                res_reg.cnt  <= cnt_reg;
                            end
                            nxt_reg   <= NX_IDLE;
                            state_reg <= ST_EMIT;
                        end
                        else if (end_c.found)
                        begin
                            cnt_reg      <= cnt_reg - CNT_W'(1);
                            rel_reg      <= rel_inc;
                            held_reg     <= new_rel;
                            held_vld_reg <= 1'b1;
                            if (held_vld_reg)
                            begin
                                res_reg      <= held_reg;
                                res_reg.last <= 1'b0;
                                nxt_reg      <= limit_hit ? NX_FLUSH : NX_LAUNCH;
                                state_reg    <= ST_EMIT;
                            end
                            else if (limit_hit)
                            begin
                                res_reg      <= new_rel;
                                res_reg.last <= 1'b1;
                                nxt_reg      <= NX_IDLE;
                                state_reg    <= ST_EMIT;
                            end
                            else
                            begin
                                launch_reg       <= '0;
                                launch_reg.act   <= 1'b1;
                                launch_reg.sched <= 1'b0;
                            end
                        end
                        else if (held_vld_reg)
                        begin
                            res_reg      <= held_reg;
                            res_reg.last <= 1'b1;
                            nxt_reg      <= NX_IDLE;
                            state_reg    <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= res_reg;
                        case (nxt_reg)
                            NX_LAUNCH:
                            begin
                                launch_reg       <= '0;
                                launch_reg.act   <= 1'b1;
                                launch_reg.sched <= 1'b0;
                                state_reg        <= ST_SWEEP;
                            end
                            NX_FLUSH:
                            begin
                                res_reg      <= held_reg;
                                res_reg.last <= 1'b1;
                                nxt_reg      <= NX_IDLE;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign released_id   = id_out(out_reg.tid);
    assign last          = out_reg.last;
    assign pending_count = cnt_out(out_reg.cnt);

    // Checks
    // a slot is claimed mid-sweep, the count follows at the end of the sweep
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SWEEP) |-> ($countones(valid_vec) == int'(cnt_reg)))
        else $error("pending count disagrees with occupied cells");

    a_one_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(act_vec))
        else $error("more than one sweep in the cell row");

    a_release_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        clr.en |-> valid_vec[clr.idx])
        else $error("release of an empty slot");

    a_accept_launches: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (launch_reg.act && (state_reg == ST_SWEEP)))
        else $error("accepted item did not start a sweep");

    a_rel_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(rel_reg) <= REL_LIMIT)
        else $error("release count past limit");

endmodule

`default_nettype wire

[hdl/dtq_cell.sv]
`default_nettype none

module dtq_cell
    import dtq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IDX_W-1:0]      cell_idx,
    input  wire logic [TIME_WIDTH-1:0] now_time,
    input  wire logic [ORDER_WIDTH-1:0] arrival,
    input  wire wr_t                   wr,
    input  wire clr_t                  clr,
    input  wire carry_t                carry_in,
    output carry_t                     carry_out,
    output logic                       valid
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [TIME_WIDTH-1:0]    dl_reg;
    logic [TASK_ID_WIDTH-1:0] tid_reg;
    logic [ORDER_WIDTH-1:0]   ord_reg;
    carry_t                   carry_reg;
    carry_t                   carry_next;

    logic [ORDER_WIDTH-1:0]   age;
    logic                     due;
    logic                     better;
    logic                     take_rel;
    logic                     take_free;

    // Candidate test: due entries compete on deadline, then on age
    assign age       = arrival - ord_reg;
    assign due       = valid_reg && !time_before(now_time, dl_reg);
    assign better    = !carry_in.found || time_before(dl_reg, carry_in.dl) ||
                       ((dl_reg == carry_in.dl) && (age > carry_in.age));
    assign take_rel  = !carry_in.sched && due && better;
    assign take_free = carry_in.sched && !carry_in.found && !valid_reg;

    // Record handed to the next cell
    always_comb
    begin
        carry_next = carry_in;
        if (take_rel || take_free)
        begin
            carry_next.found = 1'b1;
            carry_next.dl    = dl_reg;
            carry_next.age   = age;
            carry_next.idx   = cell_idx;
            carry_next.tid   = tid_reg;
        end
    end

    // Slot occupancy: claimed by a schedule sweep, freed by a release
    always_comb
    begin
        valid_next = valid_reg;
        if (carry_in.act && take_free)
            valid_next = 1'b1;
        else if (clr.en && (clr.idx == cell_idx))
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    // Entry payload, written when this slot is claimed
    always_ff @(posedge clk)
    begin
        if (carry_in.act && take_free)
        begin
            dl_reg  <= wr.dl;
            tid_reg <= wr.tid;
            ord_reg <= wr.ord;
        end
    end

    assign carry_out = carry_reg;
    assign valid     = valid_reg;

endmodule

`default_nettype wire

[verif/tb_deadline_timer_queue.sv]
`timescale 1ns / 100ps

module tb_deadline_timer_queue;
    import dtq_pkg::*;

    localparam int RANDOM_ITEMS = 88;
    localparam int QUIET_ITEMS  = 20;
    localparam int SQUEEZE_HOLD = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 80;

    // One result as it appears on the output channel
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ID_PORT_W-1:0] id;
        logic                 last;
        logic [PEND_W-1:0]    count;
    } timer_result_t;

    // Tracks the pending task set and the clock, and checks results in order
    class dtq_scoreboard;
        timer_result_t              answers_due[$];
        logic [TIME_WIDTH-1:0]      now_ticks;
        logic                       slot_busy[QUEUE_DEPTH];
        logic [TIME_WIDTH-1:0]      slot_deadline[QUEUE_DEPTH];
        logic [TASK_ID_WIDTH-1:0]   slot_task[QUEUE_DEPTH];
        logic [ORDER_WIDTH-1:0]     slot_stamp[QUEUE_DEPTH];
        logic [ORDER_WIDTH-1:0]     arrivals;
        int                         mismatches;

        function new();
            now_ticks  = '0;
            arrivals   = '0;
            mismatches = 0;
            foreach (slot_busy[i])
            begin
                slot_busy[i]     = 1'b0;
                slot_deadline[i] = '0;
                slot_task[i]     = '0;
                slot_stamp[i]    = '0;
            end
        endfunction

        // a - b as a signed time value is negative
        function automatic logic is_earlier(logic [TIME_WIDTH-1:0] a,
                                            logic [TIME_WIDTH-1:0] b);
            logic [TIME_WIDTH-1:0] diff;
            diff = a - b;
            return diff[TIME_WIDTH-1];
        endfunction

        function automatic logic [PEND_W-1:0] occupancy();
            int n;
            n = 0;
            foreach (slot_busy[i])
                if (slot_busy[i])
                    n++;
            return PEND_W'(n);
        endfunction

        // Work out the results of one accepted transfer on the input side
        function void note_item(logic m, logic [ID_PORT_W-1:0] id,
                                logic [DELAY_W-1:0] dl);
            timer_result_t            r;
            logic [TASK_ID_WIDTH-1:0] tid;
            logic [ORDER_WIDTH-1:0]   age_i;
            logic [ORDER_WIDTH-1:0]   age_b;
            int                       free_slot;
            int                       best;
            int                       released;

            tid = id[TASK_ID_WIDTH-1:0];
            if (m == MODE_SCHED)
            begin
                free_slot = -1;
                foreach (slot_busy[i])
                    if (!slot_busy[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot >= 0)
                begin
                    slot_busy[free_slot]     = 1'b1;
                    slot_deadline[free_slot] = now_ticks + TIME_WIDTH'(dl);
                    slot_task[free_slot]     = tid;
                    slot_stamp[free_slot]    = arrivals;
                    arrivals                 = arrivals + 1'b1;
                    r.kind = KIND_ACCEPTED;
                end
                else
                    r.kind = KIND_REJECTED;
                r.id    = ID_PORT_W'(tid);
                r.last  = 1'b1;
                r.count = occupancy();
                answers_due.push_back(r);
                return;
            end

            // Tick: advance time, then release due tasks earliest first
            now_ticks = now_ticks + 1'b1;
            released  = 0;
            while (released < REL_LIMIT)
            begin
                best = -1;
                foreach (slot_busy[i])
                begin
                    if (!slot_busy[i] || is_earlier(now_ticks, slot_deadline[i]))
                        continue;
                    if (best < 0)
                        best = i;
                    else if (is_earlier(slot_deadline[i], slot_deadline[best]))
                        best = i;
                    else if (slot_deadline[i] == slot_deadline[best])
                    begin
                        // equal deadlines: the older arrival goes first
                        age_i = arrivals - slot_stamp[i];
                        age_b = arrivals - slot_stamp[best];
                        if (age_i > age_b)
                            best = i;
                    end
                end
                if (best < 0)
                    break;
                slot_busy[best] = 1'b0;
                r.kind  = KIND_RELEASED;
                r.id    = ID_PORT_W'(slot_task[best]);
                r.last  = 1'b0;
                r.count = occupancy();
                answers_due.push_back(r);
                released++;
            end
            if (released > 0)
                answers_due[answers_due.size() - 1].last = 1'b1;
        endfunction

        // Compare one accepted transfer on the output side
        function void check_result(logic [KIND_W-1:0] got_kind,
                                   logic [ID_PORT_W-1:0] got_id, logic got_last,
                                   logic [PEND_W-1:0] got_count);
            timer_result_t want;

            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result kind %0d id %0d last %0d count %0d",
                             $time, got_kind, got_id, got_last, got_count);
                return;
            end
            want = answers_due.pop_front();
            if (want.kind !== got_kind || want.id !== got_id ||
                want.last !== got_last || want.count !== got_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected kind %0d id %0d last %0d count %0d,",
                             $time, want.kind, want.id, want.last, want.count,
                             " got kind %0d id %0d last %0d count %0d",
                             got_kind, got_id, got_last, got_count);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 mode = MODE_SCHED;
    logic [ID_PORT_W-1:0] task_id = '0;
    logic [DELAY_W-1:0]   delay = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    logic [KIND_W-1:0]    kind;
    logic [ID_PORT_W-1:0] released_id;
    logic                 last;
    logic [PEND_W-1:0]    pending_count;

    // quiet turns off idling near the end; squeeze_req asks for a long hold-off
    bit quiet = 1'b0;
    bit squeeze_req = 1'b0;
    bit squeeze_done = 1'b0;

    dtq_scoreboard sb = new();

    deadline_timer_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .task_id       (task_id),
        .delay         (delay),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .released_id   (released_id),
        .last          (last),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // Offer one item, possibly after a gap, and hold it until the transfer
    task automatic send_item(input logic m, input logic [ID_PORT_W-1:0] id,
                             input logic [DELAY_W-1:0] dl);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        task_id  <= id;
        delay    <= dl;
        do @(posedge clk); while (!in_ready);
        sb.note_item(m, id, dl);
    endtask

    task automatic schedule_task(input logic [ID_PORT_W-1:0] id,
                                 input logic [DELAY_W-1:0] dl);
        send_item(MODE_SCHED, id, dl);
    endtask

    // Tick fields other than mode are don't-care, so fill them with noise
    task automatic tick();
        send_item(MODE_TICK, ID_PORT_W'($urandom_range(0, 255)),
                  DELAY_W'($urandom_range(0, 65535)));
    endtask

    // Result side: check every transfer, stall in random bursts
    initial
    begin : sink
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(kind, released_id, last, pending_count);
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                out_ready <= 1'b0;
                repeat (SQUEEZE_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_deadline_timer_queue: FAIL");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        int sent;
        int n;
        int base_delay;
        logic [DELAY_W-1:0] dl;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: tick on an empty queue gives nothing
        tick();
        // all-ones delay and id: stays pending for the whole run
        schedule_task(8'hFF, 16'hFFFF);
        // zero delay is due on the very next tick
        schedule_task(8'h00, 16'h0000);
        tick();
        // fill every slot, deadlines 1..3 ahead with ties
        for (int k = 0; k < QUEUE_DEPTH - 1; k++)
            schedule_task(ID_PORT_W'(8'h10 + k), DELAY_W'((k % 3) + 1));
        // full queue rejects
        schedule_task(8'hA5, 16'h0001);
        // hold the receiver off while releases pile up and input stalls
        squeeze_req = 1'b1;
        repeat (3) tick();

        // Random: bursts of schedules with small, often equal delays, and tick runs
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (RANDOM_ITEMS - sent <= QUIET_ITEMS)
                quiet = 1'b1;
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 9) < 5)
            begin
                base_delay = $urandom_range(0, 10);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 39) == 0)
                        dl = DELAY_W'($urandom_range(0, 65535));
                    else if ($urandom_range(0, 2) == 0)
                        dl = DELAY_W'(base_delay);
                    else
                        dl = DELAY_W'($urandom_range(0, 12));
                    schedule_task(ID_PORT_W'($urandom_range(0, 255)), dl);
                end
            end
            else
                repeat (n) tick();
            sent += n;
        end
        in_valid <= 1'b0;

        // Drain, then give a tick with nothing due time to finish
        while (sb.answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.answers_due.size() == 0)
            $display("tb_deadline_timer_queue: PASS");
        else
            $display("tb_deadline_timer_queue: FAIL");
        $finish;
    end

endmodule
